// File: hw/rtl/fqcr_pkg.sv
// ----------------------------------------------------------------------------
// fqcr_pkg
// Types, codes and helpers shared by the conditional-remove queue and its
// storage cells.
// ----------------------------------------------------------------------------
package fqcr_pkg;

  localparam int QUEUE_DEPTH = 16;
  localparam int VALUE_WIDTH = 32;
  localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);

  localparam logic OP_INSERT = 1'b0;
  localparam logic OP_REMOVE = 1'b1;

  localparam logic [1:0] ST_DONE    = 2'd0;
  localparam logic [1:0] ST_EMPTY   = 2'd1;
  localparam logic [1:0] ST_NOMATCH = 2'd2;
  localparam logic [1:0] ST_FULL    = 2'd3;

  typedef logic signed [VALUE_WIDTH-1:0] entry_t;
  typedef logic [CNT_W-1:0]              count_t;

  typedef struct packed {
    logic              operation;
    logic signed [31:0] value;
  } in_beat_t;

  typedef struct packed {
    logic [1:0]         status;
    logic               is_empty;
    logic signed [31:0] head_value;
    logic [4:0]         entry_count;
  } out_beat_t;

  // Broadcast from the control to every cell in the row.
  typedef struct packed {
    logic   do_insert;
    logic   do_remove;
    entry_t key;
  } cell_ctrl_t;

  // Take the 32-bit field as a VALUE_WIDTH-bit entry.
  function automatic entry_t to_entry(logic [31:0] field);
    logic [63:0] wide;
    wide = 64'(field);
    return entry_t'(wide[VALUE_WIDTH-1:0]);
  endfunction

  // Sign-extend an entry, then cut it to the 32-bit field.
  function automatic logic [31:0] to_field(entry_t v);
    logic signed [63:0] wide;
    wide = 64'(v);
    return wide[31:0];
  endfunction

  function automatic logic [4:0] to_count_field(count_t c);
    logic [63:0] wide;
    wide = 64'(c);
    return wide[4:0];
  endfunction

endpackage

// File: hw/rtl/fqcr_cell.sv
// ----------------------------------------------------------------------------
// fqcr_cell
// One queue slot: holds an entry, compares it against the remove key and
// takes its right neighbor's entry when a match at or ahead of it closes up.
// ----------------------------------------------------------------------------
module fqcr_cell
  import fqcr_pkg::*;
(
  input  logic       clk,
  input  cell_ctrl_t ctrl,
  input  logic       occupied,
  input  logic       is_tail,
  input  logic       found_in,
  input  entry_t     right_data,
  output logic       found_out,
  output entry_t     data,
  output entry_t     data_next
);

  logic match;
  logic shift;

  assign match     = occupied && (data <= ctrl.key);
  assign found_out = found_in || match;
  assign shift     = ctrl.do_remove && found_out;

  always_comb begin
    data_next = data;
    if (ctrl.do_insert && is_tail) begin
      data_next = ctrl.key;
    end else if (shift) begin
      data_next = right_data;
    end
  end

  always_ff @(posedge clk) begin
    data <= data_next;
  end

endmodule

// File: hw/rtl/fifo_queue_conditional_remove_core.sv
// ----------------------------------------------------------------------------
// fifo_queue_conditional_remove_core
// Bounded ordered queue of signed values with insert at the tail and removal
// of the first entry, from the head, that is not greater than a key.
//
// The queue is a row of QUEUE_DEPTH cells, cell 0 at the head. An insert
// loads the cell at the tail; a remove has every occupied cell compare its
// entry with the key at once, a found flag ripples from the head along the
// row, and each cell at or behind the first match takes its right
// neighbor's entry, so the gap closes in the same cycle. Every beat in
// gives exactly one beat out, registered, in the cycle after acceptance. The
// block takes one beat per cycle; the output register stalls the input only
// while a result waits and is not being taken. The cycle time is set by the
// compare in each cell plus the ripple of the found flag across the row.
// ----------------------------------------------------------------------------
module fifo_queue_conditional_remove_core
  import fqcr_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  output logic      in_stall,
  input  in_beat_t  in_data,
  output logic      out_valid,
  input  logic      out_stall,
  output out_beat_t out_data
);

  count_t     count;
  count_t     count_next;
  logic       accept;
  logic       full;
  logic       empty;
  logic       any_match;
  logic [1:0] status_next;
  logic       out_valid_next;
  cell_ctrl_t ctrl;

  entry_t               cell_data      [QUEUE_DEPTH];
  entry_t               cell_data_next [QUEUE_DEPTH];
  logic [QUEUE_DEPTH:0] found;

  assign in_stall = out_valid && out_stall;
  assign accept   = in_valid && !in_stall;
  assign full     = (count == count_t'(QUEUE_DEPTH));
  assign empty    = (count == '0);

  assign ctrl.key       = to_entry(in_data.value);
  assign ctrl.do_insert = accept && (in_data.operation == OP_INSERT) && !full;
  assign ctrl.do_remove = accept && (in_data.operation == OP_REMOVE);

  assign found[0]  = 1'b0;
  assign any_match = found[QUEUE_DEPTH];

  for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
    entry_t right;
    if (i == QUEUE_DEPTH - 1) begin : g_last
      assign right = cell_data[i];
    end else begin : g_mid
      assign right = cell_data[i+1];
    end

    fqcr_cell u_cell (
      .clk       (clk),
      .ctrl      (ctrl),
      .occupied  (count > count_t'(i)),
      .is_tail   (count == count_t'(i)),
      .found_in  (found[i]),
      .right_data(right),
      .found_out (found[i+1]),
      .data      (cell_data[i]),
      .data_next (cell_data_next[i])
    );
  end

  always_comb begin
    count_next  = count;
    status_next = ST_DONE;
    if (in_data.operation == OP_INSERT) begin
      if (full) begin
        status_next = ST_FULL;
      end else begin
        count_next = count + count_t'(1);
      end
    end else if (empty) begin
      status_next = ST_EMPTY;
    end else if (!any_match) begin
      status_next = ST_NOMATCH;
    end else begin
      count_next = count - count_t'(1);
    end
  end

  // Hold the result until taken; a new beat may replace it in the same cycle.
  assign out_valid_next = accept || (out_valid && out_stall);

  always_ff @(posedge clk) begin
    if (rst) begin
      count     <= '0;
      out_valid <= 1'b0;
    end else begin
      out_valid <= out_valid_next;
      if (accept) begin
        count <= count_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      out_data.status      <= status_next;
      out_data.is_empty    <= (count_next == '0);
      out_data.head_value  <= (count_next == '0) ? 32'sd0 : to_field(cell_data_next[0]);
      out_data.entry_count <= to_count_field(count_next);
    end
  end

`ifndef NO_ASSERTIONS
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= count_t'(QUEUE_DEPTH))
    else $error("entry count beyond queue depth");

  a_empty_head: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.is_empty |-> out_data.head_value == 32'sd0)
    else $error("empty result carries a head value");

  a_count_out: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> out_data.entry_count == to_count_field(count))
    else $error("reported count differs from held count");

  a_insert_grow: assert property (@(posedge clk) disable iff (rst)
    ctrl.do_insert |=> count == $past(count) + count_t'(1))
    else $error("insert did not advance the count");
`endif

endmodule

// File: sim/fifo_queue_conditional_remove_core_test.sv
// ----------------------------------------------------------------------------
// fifo_queue_conditional_remove_core_test
// Drives inserts and conditional removes into the queue and checks every
// result beat, field by field, against a shadow copy of the queue kept in
// the bench, or against a literal beat given in some rows of a short directed
// table. The table covers the edge values, a full queue, an empty queue and
// a key that matches nothing. A long random run follows, biased in phases
// toward filling or draining. Both handshakes idle and stall at random.
// ----------------------------------------------------------------------------
module fifo_queue_conditional_remove_core_test;
  import fqcr_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int NUM_DIRECTED = 25;
  localparam int NUM_RANDOM   = 600;
  localparam int PAUSE_AT     = 300;
  localparam logic signed [31:0] VAL_MAX = 32'sh7FFF_FFFF;
  localparam logic signed [31:0] VAL_MIN = 32'sh8000_0000;

  typedef struct packed {
    logic               operation;
    logic signed [31:0] value;
    logic               has_lit;
    out_beat_t          lit;
  } directed_row_t;

  localparam out_beat_t NO_LIT = '0;

  localparam directed_row_t DIRECTED_ROWS [NUM_DIRECTED] = '{
    '{OP_REMOVE, 32'sd0,          1'b1, '{ST_EMPTY,   1'b1, 32'sd0,  5'd0}},
    '{OP_INSERT, VAL_MAX,         1'b1, '{ST_DONE,    1'b0, VAL_MAX, 5'd1}},
    '{OP_REMOVE, VAL_MAX - 1,     1'b1, '{ST_NOMATCH, 1'b0, VAL_MAX, 5'd1}},
    '{OP_INSERT, VAL_MIN,         1'b1, '{ST_DONE,    1'b0, VAL_MAX, 5'd2}},
    '{OP_REMOVE, VAL_MIN,         1'b1, '{ST_DONE,    1'b0, VAL_MAX, 5'd1}},
    '{OP_REMOVE, VAL_MAX,         1'b1, '{ST_DONE,    1'b1, 32'sd0,  5'd0}},
    '{OP_INSERT, 32'sd0,          1'b0, NO_LIT},
    '{OP_INSERT, -32'sd1,         1'b0, NO_LIT},
    '{OP_INSERT, 32'sd1,          1'b0, NO_LIT},
    '{OP_INSERT, 32'sd100,        1'b0, NO_LIT},
    '{OP_INSERT, -32'sd100,       1'b0, NO_LIT},
    '{OP_INSERT, VAL_MAX,         1'b0, NO_LIT},
    '{OP_INSERT, VAL_MIN,         1'b0, NO_LIT},
    '{OP_INSERT, 32'sd7,          1'b0, NO_LIT},
    '{OP_INSERT, 32'sd7,          1'b0, NO_LIT},
    '{OP_INSERT, 32'sd55555,      1'b0, NO_LIT},
    '{OP_INSERT, -32'sd123456,    1'b0, NO_LIT},
    '{OP_INSERT, 32'sd3,          1'b0, NO_LIT},
    '{OP_INSERT, 32'sd2,          1'b0, NO_LIT},
    '{OP_INSERT, 32'sd1000,       1'b0, NO_LIT},
    '{OP_INSERT, -32'sd5,         1'b0, NO_LIT},
    '{OP_INSERT, 32'sd42,         1'b0, NO_LIT},
    '{OP_INSERT, 32'sd9,          1'b1, '{ST_FULL,    1'b0, 32'sd0,  5'd16}},
    '{OP_REMOVE, VAL_MIN,         1'b0, NO_LIT},
    '{OP_REMOVE, -32'sd200000,    1'b0, NO_LIT}
  };

  logic      clk;
  logic      rst;
  logic      in_valid;
  logic      in_stall;
  in_beat_t  in_data;
  logic      out_valid;
  logic      out_stall;
  out_beat_t out_data;

  entry_t    shadow_entries [QUEUE_DEPTH];
  int        shadow_count;
  out_beat_t expected_beats [$];
  int        errors;
  logic      quiet;
  int        stall_left;

  fifo_queue_conditional_remove_core u_dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Apply one operation to the shadow queue and return the beat it yields.
  function automatic out_beat_t shadow_queue_op(in_beat_t b);
    out_beat_t r;
    entry_t    key;
    int        hit;
    r.status = ST_DONE;
    key = $signed(b.value);
    if (b.operation == OP_INSERT) begin
      if (shadow_count >= QUEUE_DEPTH) begin
        r.status = ST_FULL;
      end else begin
        shadow_entries[shadow_count] = key;
        shadow_count++;
      end
    end else if (shadow_count == 0) begin
      r.status = ST_EMPTY;
    end else begin
      hit = -1;
      for (int i = 0; i < shadow_count; i++) begin
        if (hit < 0 && $signed(shadow_entries[i]) <= key) hit = i;
      end
      if (hit < 0) begin
        r.status = ST_NOMATCH;
      end else begin
        // close the gap, keeping order
        for (int i = hit; i + 1 < shadow_count; i++) shadow_entries[i] = shadow_entries[i + 1];
        shadow_count--;
      end
    end
    r.is_empty    = (shadow_count == 0);
    r.head_value  = (shadow_count == 0) ? 32'sd0 : shadow_entries[0];
    r.entry_count = 5'(shadow_count);
    return r;
  endfunction

  // Mostly short idles, now and then a long one, none in quiet stretches.
  function automatic int pick_idle();
    int r;
    if (quiet) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  function automatic in_beat_t make_random_beat(int insert_pct);
    in_beat_t b;
    int       pick;
    b.operation = ($urandom_range(0, 99) < insert_pct) ? OP_INSERT : OP_REMOVE;
    pick = $urandom_range(0, 9);
    if (b.operation == OP_REMOVE && shadow_count > 0 && pick < 4) begin
      // key near a held entry: exact hit, one below, one above
      b.value = shadow_entries[$urandom_range(0, shadow_count - 1)]
                + 32'(int'($urandom_range(0, 2)) - 1);
    end else if (pick < 6) begin
      b.value = $urandom;
    end else if (pick < 8) begin
      b.value = 32'(int'($urandom_range(0, 200)) - 100);
    end else if (pick == 8) begin
      b.value = VAL_MIN;
    end else begin
      b.value = VAL_MAX;
    end
    return b;
  endfunction

  // Hold the beat until it is taken, then record what it should produce.
  task automatic send_beat(in_beat_t b, logic has_lit, out_beat_t lit);
    out_beat_t predicted;
    in_valid <= 1'b1;
    in_data  <= b;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    predicted = shadow_queue_op(b);
    expected_beats.push_back(has_lit ? lit : predicted);
  endtask

  task automatic idle_then_send(in_beat_t b, logic has_lit, out_beat_t lit, logic drain);
    int idle;
    idle = pick_idle();
    if (drain && idle == 0) idle = 1;
    if (idle > 0) begin
      in_valid <= 1'b0;
      repeat (idle) @(posedge clk);
      while (drain && expected_beats.size() != 0) @(posedge clk);
    end
    send_beat(b, has_lit, lit);
  endtask

  initial begin
    in_beat_t b;
    int       insert_pct;
    rst          = 1'b1;
    in_valid     = 1'b0;
    in_data      = '0;
    errors       = 0;
    quiet        = 1'b0;
    shadow_count = 0;
    foreach (shadow_entries[i]) shadow_entries[i] = '0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    foreach (DIRECTED_ROWS[i]) begin
      b.operation = DIRECTED_ROWS[i].operation;
      b.value     = DIRECTED_ROWS[i].value;
      idle_then_send(b, DIRECTED_ROWS[i].has_lit, DIRECTED_ROWS[i].lit, 1'b0);
    end

    insert_pct = 50;
    for (int n = 0; n < NUM_RANDOM; n++) begin
      if (n % 40 == 0) begin
        case ($urandom_range(0, 2))
          0:       insert_pct = 85;
          1:       insert_pct = 50;
          default: insert_pct = 20;
        endcase
        quiet <= ($urandom_range(0, 3) == 0);
      end
      b = make_random_beat(insert_pct);
      idle_then_send(b, 1'b0, NO_LIT, n == PAUSE_AT);
    end
    in_valid <= 1'b0;

    while (expected_beats.size() != 0) @(posedge clk);
    repeat (5) @(posedge clk);
    if (errors == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  // Receiver: stall in bursts, mostly short, now and then long.
  always @(posedge clk) begin
    if (rst) begin
      out_stall  <= 1'b0;
      stall_left <= 0;
    end else if (stall_left != 0) begin
      out_stall  <= 1'b1;
      stall_left <= stall_left - 1;
    end else if (!quiet && $urandom_range(0, 99) < 30) begin
      out_stall  <= 1'b1;
      stall_left <= ($urandom_range(0, 9) == 0) ? $urandom_range(8, 30) : $urandom_range(0, 2);
    end else begin
      out_stall <= 1'b0;
    end
  end

  always @(posedge clk) begin
    out_beat_t exp_beat;
    if (!rst && out_valid && !out_stall) begin
      if (expected_beats.size() == 0) begin
        $display("%0t: result beat with none expected: %p", $time, out_data);
        errors++;
      end else begin
        exp_beat = expected_beats.pop_front();
        if (out_data.status !== exp_beat.status) begin
          $display("%0t: status expected %0d, got %0d", $time, exp_beat.status, out_data.status);
          errors++;
        end
        if (out_data.is_empty !== exp_beat.is_empty) begin
          $display("%0t: is_empty expected %0b, got %0b", $time, exp_beat.is_empty,
                   out_data.is_empty);
          errors++;
        end
        if (out_data.head_value !== exp_beat.head_value) begin
          $display("%0t: head_value expected %0d, got %0d", $time, exp_beat.head_value,
                   out_data.head_value);
          errors++;
        end
        if (out_data.entry_count !== exp_beat.entry_count) begin
          $display("%0t: entry_count expected %0d, got %0d", $time, exp_beat.entry_count,
                   out_data.entry_count);
          errors++;
        end
      end
    end
  end

  initial begin
    #5_000_000;
    $display("Simulation FAILED");
    $finish;
  end

endmodule

// File: filelist.f
hw/rtl/fqcr_pkg.sv
hw/rtl/fqcr_cell.sv
hw/rtl/fifo_queue_conditional_remove_core.sv
sim/fifo_queue_conditional_remove_core_test.sv
